// ----- hdl/gce_pkg.sv -----
`default_nettype none

package gce_pkg;

    // Largest glyph dimension accepted; wider values saturate here.
    localparam int MAX_GLYPH = 72;
    localparam int DIM_LIM   = (MAX_GLYPH > 127) ? 127 : MAX_GLYPH;

    localparam logic [6:0]  WIDTH_RST  = 7'd8;
    localparam logic [6:0]  HEIGHT_RST = 7'd16;
    localparam logic [15:0] FG_RST     = 16'hFFFF;
    localparam logic [15:0] BG_RST     = 16'h0000;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_FG     = 2'd2,
        REG_BG     = 2'd3
    } cfg_reg_t;

    // Zero reads as one, above the limit saturates.
    function automatic logic [6:0] clamp_dim(input logic [6:0] v);
        logic [6:0] r;
        begin
            r = v;
            if (v == 7'd0)
            begin
                r = 7'd1;
            end
            else if (v > 7'(DIM_LIM))
            begin
                r = 7'(DIM_LIM);
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ----- hdl/glyph_color_expander_top.sv -----
// Channel   Handshake            Payload
// in        in_valid/in_ready    bitmap_byte[7:0]
// out       out_valid/out_ready  pixel_value[15:0], row_end, glyph_end, last
// cfg       cfg_valid/cfg_ready  cfg_index[1:0], cfg_data[15:0]
//
// Each byte gives 1 to 8 pixels, one pixel per cycle through the output
// register while the output is not stalled; the byte hold register and its
// pixel counter step through the pixels. The next byte is taken in the cycle its
// predecessor's last pixel moves to the output register.
// Reset clears counters, valids and config to their defaults.
// A stalled output holds its beat; the hold stage stops behind it.
`default_nettype none

module glyph_color_expander_top
    import gce_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  bitmap_byte,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      pixel_value,
    output logic             row_end,
    output logic             glyph_end,
    output logic             last,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic [6:0]  width_reg;
    logic [6:0]  height_reg;
    logic [15:0] fg_reg;
    logic [15:0] bg_reg;

    logic [3:0]  byte_in_row_reg;
    logic [3:0]  byte_in_row_next;
    logic [6:0]  row_index_reg;
    logic [6:0]  row_index_next;

    logic        hold_valid_reg;
    logic [7:0]  hold_data_reg;
    logic [3:0]  hold_n_reg;
    logic [2:0]  hold_k_reg;
    logic        hold_row_last_reg;
    logic        hold_glyph_last_reg;

    logic        out_valid_reg;
    logic [15:0] pixel_reg;
    logic        row_end_reg;
    logic        glyph_end_reg;
    logic        last_reg;

    logic        in_fire;
    logic        move;
    logic        hold_fin;
    logic        hold_done;

    logic [6:0]  w;
    logic [6:0]  h;
    logic [4:0]  row_bytes;
    logic [3:0]  b;
    logic [6:0]  r;
    logic [6:0]  remain;
    logic [3:0]  n_pix;
    logic        row_last;
    logic        glyph_last;
    logic        pix_bit;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            fg_reg     <= FG_RST;
            bg_reg     <= BG_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data[6:0];
                REG_HEIGHT: height_reg <= cfg_data[6:0];
                REG_FG:     fg_reg     <= cfg_data;
                REG_BG:     bg_reg     <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Position and pixel count of the incoming byte
    always_comb
    begin
        w          = clamp_dim(width_reg);
        h          = clamp_dim(height_reg);
        row_bytes  = 5'((8'(w) + 8'd7) >> 3);
        b          = ({1'b0, byte_in_row_reg} >= row_bytes) ? 4'd0 : byte_in_row_reg;
        r          = (row_index_reg >= h) ? 7'd0 : row_index_reg;
        remain     = w - {b, 3'b000};
        n_pix      = (remain > 7'd8) ? 4'd8 : remain[3:0];
        row_last   = (5'({1'b0, b} + 5'd1) == row_bytes);
        glyph_last = row_last && ((r + 7'd1) == h);

        if (row_last)
        begin
            byte_in_row_next = 4'd0;
            row_index_next   = glyph_last ? 7'd0 : (r + 7'd1);
        end
        else
        begin
            byte_in_row_next = b + 4'd1;
            row_index_next   = r;
        end
    end

    assign move      = hold_valid_reg && (!out_valid_reg || out_ready);
    assign hold_fin  = ({1'b0, hold_k_reg} + 4'd1) == hold_n_reg;
    assign hold_done = move && hold_fin;
    assign in_ready  = !hold_valid_reg || hold_done;
    assign in_fire   = in_valid && in_ready;
    assign pix_bit   = hold_data_reg[3'd7 - hold_k_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_in_row_reg <= 4'd0;
            row_index_reg   <= 7'd0;
            hold_valid_reg  <= 1'b0;
            hold_k_reg      <= 3'd0;
        end
        else
        begin
            if (in_fire)
            begin
                byte_in_row_reg <= byte_in_row_next;
                row_index_reg   <= row_index_next;
                hold_valid_reg  <= 1'b1;
                hold_k_reg      <= 3'd0;
            end
            else if (hold_done)
            begin
                hold_valid_reg <= 1'b0;
            end
            else if (move)
            begin
                hold_k_reg <= hold_k_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            hold_data_reg       <= bitmap_byte;
            hold_n_reg          <= n_pix;
            hold_row_last_reg   <= row_last;
            hold_glyph_last_reg <= glyph_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            pixel_reg     <= pix_bit ? fg_reg : bg_reg;
            row_end_reg   <= hold_fin && hold_row_last_reg;
            glyph_end_reg <= hold_fin && hold_glyph_last_reg;
            last_reg      <= hold_fin;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_value = pixel_reg;
    assign row_end     = row_end_reg;
    assign glyph_end   = glyph_end_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

// ----- hdl/gce_checker.sv -----
`default_nettype none

module gce_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] pixel_value,
    input wire logic        row_end,
    input wire logic        glyph_end,
    input wire logic        last
);

    // glyph end only on a row end
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && glyph_end |-> row_end)
        else $error("glyph_end without row_end");

    // row end only on the final pixel of a byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && row_end |-> last)
        else $error("row_end without last");

    // an accepted byte shows a pixel on the output
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##2 out_valid)
        else $error("accepted byte produced no pixel");

    // stalled beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_value)
            && $stable(row_end) && $stable(glyph_end) && $stable(last))
        else $error("stalled output beat changed");

endmodule

bind glyph_color_expander_top gce_checker u_gce_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_value (pixel_value),
    .row_end     (row_end),
    .glyph_end   (glyph_end),
    .last        (last)
);

`default_nettype wire

// ----- tb/glyph_color_expander_top_tb.sv -----
module glyph_color_expander_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gce_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int LIMIT_CYCLES = 200_000;
    localparam int RANDOM_BYTES = 140;

    typedef struct packed {
        logic [15:0] color;
        logic        row_end;
        logic        glyph_end;
        logic        last;
    } pixel_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [7:0]  bitmap_byte = 8'h00;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [15:0] pixel_value;
    logic        row_end;
    logic        glyph_end;
    logic        last;
    logic        cfg_valid   = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index   = 2'd0;
    logic [15:0] cfg_data    = 16'h0000;

    // predictor copy of the register file and glyph position
    logic [6:0]  cfg_width  = WIDTH_RST;
    logic [6:0]  cfg_height = HEIGHT_RST;
    logic [15:0] cfg_fg     = FG_RST;
    logic [15:0] cfg_bg     = BG_RST;
    logic [3:0]  col_byte   = 4'd0;
    logic [6:0]  row_cnt    = 7'd0;

    logic [7:0]  bitmap_backlog[$];
    pixel_t      pixel_expect_q[$];

    int unsigned bytes_queued  = 0;
    int unsigned bytes_taken   = 0;
    int unsigned pixels_seen   = 0;
    int unsigned glyphs_seen   = 0;
    int unsigned reg_writes    = 0;
    int unsigned fail_count    = 0;
    int unsigned cycle_count   = 0;
    int unsigned in_gap_pct    = 28;
    int unsigned out_stall_pct = 28;

    glyph_color_expander_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .bitmap_byte (bitmap_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_value (pixel_value),
        .row_end     (row_end),
        .glyph_end   (glyph_end),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    function automatic int unsigned sat_dim(input logic [6:0] v);
        if (v == 7'd0)
        begin
            return 1;
        end
        if (int'(v) > DIM_LIM)
        begin
            return DIM_LIM;
        end
        return 32'(v);
    endfunction

    // Expected pixels for one accepted bitmap byte; advances the position.
    task automatic expand_byte(input logic [7:0] data);
        int unsigned w, h, bpr, b, r, n, k;
        logic        row_done, glyph_done;
        pixel_t      px;
        w   = sat_dim(cfg_width);
        h   = sat_dim(cfg_height);
        bpr = (w + 7) / 8;
        b   = 32'(col_byte);
        r   = 32'(row_cnt);
        // position left over from an earlier geometry restarts the row/glyph
        if (b >= bpr)
        begin
            b = 0;
        end
        if (r >= h)
        begin
            r = 0;
        end
        n = w - b * 8;
        if (n > 8)
        begin
            n = 8;
        end
        row_done   = (b + 1 == bpr);
        glyph_done = row_done && (r + 1 == h);
        for (k = 0; k < n; k++)
        begin
            px.color     = data[7 - k] ? cfg_fg : cfg_bg;
            px.last      = (k + 1 == n);
            px.row_end   = px.last && row_done;
            px.glyph_end = px.last && glyph_done;
            pixel_expect_q.push_back(px);
        end
        if (row_done)
        begin
            col_byte = 4'd0;
            row_cnt  = glyph_done ? 7'd0 : 7'(r + 1);
        end
        else
        begin
            col_byte = 4'(b + 1);
            row_cnt  = 7'(r);
        end
    endtask

    // Byte driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expand_byte(bitmap_byte);
                bytes_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (bitmap_backlog.size() != 0 && $urandom_range(99) >= in_gap_pct)
                begin
                    in_valid    <= 1'b1;
                    bitmap_byte <= bitmap_backlog.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Pixel monitor
    always @(posedge clk)
    begin : pixel_mon
        pixel_t want;
        if (rst_n && out_valid && out_ready)
        begin
            pixels_seen++;
            if (glyph_end)
            begin
                glyphs_seen++;
            end
            if (pixel_expect_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display("ERROR: unexpected pixel %h row_end %b glyph_end %b last %b",
                             pixel_value, row_end, glyph_end, last);
                end
            end
            else
            begin
                want = pixel_expect_q.pop_front();
                if (want.color !== pixel_value || want.row_end !== row_end ||
                    want.glyph_end !== glyph_end || want.last !== last)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("ERROR: pixel %0d exp %h/%b/%b/%b got %h/%b/%b/%b",
                                 pixels_seen, want.color, want.row_end, want.glyph_end,
                                 want.last, pixel_value, row_end, glyph_end, last);
                    end
                end
            end
        end
        out_ready <= rst_n && ($urandom_range(99) >= out_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout: %0d bytes queued, %0d taken, %0d pixels pending",
                     bytes_queued, bytes_taken, pixel_expect_q.size());
            $display("** glyph_color_expander_top: FAILED **");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        bitmap_backlog.push_back(b);
        bytes_queued++;
    endtask

    task automatic queue_random(input int unsigned count);
        repeat (count)
        begin
            push_byte(8'($urandom_range(255)));
        end
    endtask

    // Wait until every queued byte went in and all its pixels came out.
    task automatic drain();
        while (bytes_taken != bytes_queued || pixel_expect_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        case (idx)
            REG_WIDTH:  cfg_width  = val[6:0];
            REG_HEIGHT: cfg_height = val[6:0];
            REG_FG:     cfg_fg     = val;
            REG_BG:     cfg_bg     = val;
            default:    ;
        endcase
        reg_writes++;
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int unsigned phase, glyph_bytes, n_bytes, head, rand_bytes;
        logic [6:0]  w_code, h_code;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry 8x16: one byte per row, rows 0..3
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'hA5);
        push_byte(8'h5A);
        drain();

        // zero dims read as 1x1; row counter is stale at this point
        write_reg(REG_WIDTH, 16'hFF80);
        write_reg(REG_HEIGHT, 16'h0000);
        write_reg(REG_FG, 16'h0000);
        write_reg(REG_BG, 16'hFFFF);
        push_byte(8'h80);
        push_byte(8'h7F);
        drain();

        // 13 wide: second byte of each row is cut to 5 pixels
        write_reg(REG_WIDTH, 16'h000D);
        write_reg(REG_HEIGHT, 16'h0003);
        write_reg(REG_FG, 16'hF800);
        write_reg(REG_BG, 16'h07E0);
        push_byte(8'h3C);
        push_byte(8'hC3);
        push_byte(8'h96);
        drain();
        // shrink width mid-row: byte position is now stale
        write_reg(REG_WIDTH, 16'hAA08);
        push_byte(8'h0F);
        push_byte(8'hF0);
        drain();

        // oversize dims saturate to the limit
        write_reg(REG_WIDTH, 16'h007F);
        write_reg(REG_HEIGHT, 16'h0064);
        write_reg(REG_FG, 16'hFFFF);
        write_reg(REG_BG, 16'h0000);
        for (int i = 0; i < 8; i++)
        begin
            push_byte(8'h01 << i);
        end
        push_byte(8'hFF);
        push_byte(8'h00);
        drain();

        rand_bytes = 0;
        phase      = 0;
        while (rand_bytes < RANDOM_BYTES)
        begin
            case ($urandom_range(9))
                0:       w_code = 7'd0;
                1:       w_code = 7'(DIM_LIM);
                2:       w_code = 7'($urandom_range(DIM_LIM + 1, 127));
                3:       w_code = 7'd1;
                default: w_code = 7'($urandom_range(2, 24));
            endcase
            case ($urandom_range(9))
                0:       h_code = 7'd0;
                1:       h_code = 7'($urandom_range(DIM_LIM, 127));
                2:       h_code = 7'd1;
                default: h_code = 7'($urandom_range(1, 4));
            endcase
            write_reg(REG_WIDTH, {7'($urandom_range(511)), 2'b00, w_code} | 16'h0000);
            write_reg(REG_HEIGHT, {9'($urandom_range(511)), h_code});
            if ($urandom_range(1) == 0 || phase == 0)
            begin
                write_reg(REG_FG, 16'($urandom_range(65535)));
                write_reg(REG_BG, 16'($urandom_range(65535)));
            end

            // mostly whole glyphs; sometimes a ragged tail
            glyph_bytes = ((sat_dim(w_code) + 7) / 8) * sat_dim(h_code);
            if (glyph_bytes <= 32)
            begin
                n_bytes = glyph_bytes * $urandom_range(1, 32 / glyph_bytes);
            end
            else
            begin
                n_bytes = $urandom_range(4, 24);
            end
            if ($urandom_range(7) == 0)
            begin
                n_bytes += $urandom_range(1, 5);
            end

            // one phase runs back-to-back with no gaps on either side
            if (phase == 2)
            begin
                in_gap_pct    = 0;
                out_stall_pct = 0;
                if (n_bytes < 32)
                begin
                    if (glyph_bytes <= 32)
                    begin
                        n_bytes += glyph_bytes * ((32 - n_bytes) / glyph_bytes + 1);
                    end
                    else
                    begin
                        n_bytes = 32;
                    end
                end
            end
            else
            begin
                in_gap_pct    = 28;
                out_stall_pct = 28;
            end

            if (phase != 2 && (phase == 0 || $urandom_range(2) == 0))
            begin
                // sender holds off until the pipeline has emptied
                head = $urandom_range(1, n_bytes);
                queue_random(head);
                drain();
                queue_random(n_bytes - head);
            end
            else
            begin
                queue_random(n_bytes);
            end
            drain();
            rand_bytes += n_bytes;
            phase++;
        end

        drain();
        repeat (16) @(posedge clk);
        $display("Covered %0d bytes -> %0d pixels, %0d glyph ends, %0d register writes",
                 bytes_taken, pixels_seen, glyphs_seen, reg_writes);
        $display("Dims from zero to saturated, partial bytes, stale row/byte positions");
        if (fail_count == 0)
        begin
            $display("** glyph_color_expander_top: PASSED **");
        end
        else
        begin
            $display("%0d failures", fail_count);
            $display("** glyph_color_expander_top: FAILED **");
        end
        $finish;
    end

endmodule
